// ===== design/swb_pkg.sv =====
`timescale 1ns / 1ps
// package for the subtract-with-borrow generator: widths, rom and codes
package swb_pkg;
  localparam int unsigned VAL_W = 31;
  localparam int unsigned LONG_LAG = 48;
  localparam int unsigned SHORT_LAG = 8;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned ROM_LEN = 800;
  localparam int unsigned ROM_AW = 10;
  localparam int unsigned ROM_STEP = 10;
  localparam int unsigned ROM_W = 18;
  localparam int unsigned POS_W = 8;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LONG_LAG - 1);
  localparam logic [IDX_W-1:0] SHORT_START = IDX_W'(LONG_LAG - 1 - SHORT_LAG);
  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam logic [ROM_W-1:0] SEED_ROM [ROM_LEN] = '{
18'h3462f, 18'h009aa, 18'h2e383, 18'h137a9, 18'h07247, 18'h35b20, 18'h064f0, 18'h2ea03,
18'h35b39, 18'h36d0f, 18'h05f58, 18'h14502, 18'h20488, 18'h0f7a0, 18'h25b4c, 18'h02d91,
18'h195da, 18'h2f5e5, 18'h26817, 18'h05c4f, 18'h2277a, 18'h317b7, 18'h1a409, 18'h1aff1,
18'h29787, 18'h1888a, 18'h1f9da, 18'h18e81, 18'h0dfda, 18'h3a3d2, 18'h3d0e8, 18'h2e6fa,
18'h2e646, 18'h3eab5, 18'h0edc2, 18'h22ed0, 18'h17a30, 18'h1da42, 18'h19d93, 18'h256e4,
18'h39d35, 18'h01121, 18'h19f5d, 18'h31d88, 18'h3bb76, 18'h347c7, 18'h3c340, 18'h1787c,
18'h16b22, 18'h34d38, 18'h3e785, 18'h1f85d, 18'h0fed6, 18'h2a96f, 18'h29a66, 18'h17759,
18'h3244c, 18'h3ee64, 18'h26aa5, 18'h2bf08, 18'h041f2, 18'h3789c, 18'h32f7a, 18'h0cd06,
18'h3b933, 18'h3881a, 18'h260a5, 18'h0f582, 18'h1fa67, 18'h13296, 18'h2b2b6, 18'h16950,
18'h0fe67, 18'h1ae59, 18'h10aa7, 18'h1292e, 18'h16960, 18'h1e0bb, 18'h31057, 18'h3a5e0,
18'h2e0d5, 18'h1b77f, 18'h39dfe, 18'h3b991, 18'h3bd51, 18'h1f16b, 18'h0555a, 18'h0fd11,
18'h342a8, 18'h2860f, 18'h37f4f, 18'h1e122, 18'h2109e, 18'h1c4be, 18'h3eb7b, 18'h1599f,
18'h0b5fb, 18'h28ea5, 18'h1d3ba, 18'h0c51a, 18'h0bca9, 18'h1d827, 18'h3fe84, 18'h0c2d4,
18'h29c7c, 18'h2853f, 18'h1af59, 18'h39d96, 18'h0c19c, 18'h2494c, 18'h14add, 18'h369c0,
18'h03dcd, 18'h04b0b, 18'h09206, 18'h2f179, 18'h15c9d, 18'h05293, 18'h39a5e, 18'h2acb5,
18'h0f4f4, 18'h226bb, 18'h04d83, 18'h2e243, 18'h1ee88, 18'h0e321, 18'h07a5d, 18'h00ef5,
18'h27fc8, 18'h2b2ad, 18'h38b77, 18'h27928, 18'h01aa1, 18'h182a6, 18'h3ed24, 18'h301d7,
18'h1ffe2, 18'h0ef1a, 18'h2cf21, 18'h181b7, 18'h0a09b, 18'h3ec4c, 18'h2a1f8, 18'h0a98e,
18'h308ad, 18'h2d701, 18'h23b06, 18'h005cd, 18'h301db, 18'h155fd, 18'h3bc1f, 18'h2d32f,
18'h394a0, 18'h3c326, 18'h05d5a, 18'h3e731, 18'h21a1c, 18'h19cf0, 18'h28d67, 18'h0ca4a,
18'h3717d, 18'h27a09, 18'h190db, 18'h00a99, 18'h38993, 18'h3f4a1, 18'h04b6e, 18'h2ae6e,
18'h147aa, 18'h38a8e, 18'h1f87a, 18'h02715, 18'h3a4ea, 18'h12839, 18'h26697, 18'h0d2bc,
18'h096d5, 18'h23ddf, 18'h00075, 18'h39802, 18'h17707, 18'h39dc4, 18'h0cbbc, 18'h37c34,
18'h3b5ad, 18'h22f81, 18'h1a195, 18'h3c430, 18'h17229, 18'h001a1, 18'h374cf, 18'h0beb2,
18'h01c64, 18'h118b9, 18'h35e27, 18'h0469f, 18'h02fb2, 18'h13d66, 18'h34829, 18'h1930f,
18'h1fc50, 18'h3a375, 18'h2aed1, 18'h0a342, 18'h32bb3, 18'h27bf6, 18'h16a9f, 18'h3a934,
18'h1ffc3, 18'h08079, 18'h1568c, 18'h35ca8, 18'h15357, 18'h141af, 18'h3326f, 18'h2debb,
18'h3812d, 18'h3935a, 18'h38eb9, 18'h15694, 18'h19d1c, 18'h1a570, 18'h12233, 18'h2773f,
18'h1bc3e, 18'h3e96c, 18'h2ab52, 18'h14b62, 18'h1e89f, 18'h00a83, 18'h3f04e, 18'h18e5c,
18'h107b4, 18'h39fa8, 18'h0cc8b, 18'h33a46, 18'h3a908, 18'h2c6e5, 18'h31df2, 18'h12ef3,
18'h177c6, 18'h1159f, 18'h00c00, 18'h3a342, 18'h1a2f7, 18'h14170, 18'h08fa4, 18'h1c480,
18'h177b9, 18'h048c8, 18'h30dc8, 18'h16525, 18'h3cc7f, 18'h38c1d, 18'h2187e, 18'h19205,
18'h2490d, 18'h367cf, 18'h29260, 18'h20f59, 18'h2e943, 18'h0afe7, 18'h2d5ee, 18'h329b8,
18'h14be3, 18'h3d842, 18'h26a86, 18'h140e9, 18'h12de4, 18'h25462, 18'h13fe6, 18'h302b1,
18'h20eea, 18'h19cc5, 18'h26e51, 18'h1faf4, 18'h1ab5c, 18'h2f756, 18'h2e1b9, 18'h0955e,
18'h13b48, 18'h209bb, 18'h1ba17, 18'h2cc4e, 18'h17fc3, 18'h19887, 18'h20fc1, 18'h3c09d,
18'h3add6, 18'h254e3, 18'h3e26a, 18'h13989, 18'h18739, 18'h34676, 18'h177c9, 18'h138bf,
18'h201e8, 18'h38ef5, 18'h16136, 18'h1ab86, 18'h0176e, 18'h1a7bd, 18'h36787, 18'h14ccb,
18'h2bf30, 18'h371b3, 18'h0a019, 18'h0d4b8, 18'h2374c, 18'h23948, 18'h3e691, 18'h379d5,
18'h299cf, 18'h0e46d, 18'h26fe6, 18'h15bbf, 18'h364f1, 18'h036c9, 18'h39aea, 18'h30889,
18'h28a8c, 18'h311ab, 18'h088f3, 18'h2f459, 18'h307d6, 18'h0910f, 18'h1ca45, 18'h16c28,
18'h17a1d, 18'h1eac8, 18'h17522, 18'h11eb5, 18'h0da8f, 18'h2c8e3, 18'h25eb9, 18'h0867b,
18'h08e2b, 18'h0493b, 18'h08639, 18'h3f797, 18'h0603e, 18'h29c78, 18'h2bf01, 18'h36e96,
18'h3c3d2, 18'h30cb1, 18'h1f2c4, 18'h33f06, 18'h2081d, 18'h16f20, 18'h206e4, 18'h346f1,
18'h0ede0, 18'h09668, 18'h30fbe, 18'h12299, 18'h3b654, 18'h1d221, 18'h16b5c, 18'h37990,
18'h1e26b, 18'h0a791, 18'h2e3f5, 18'h01a9d, 18'h2f474, 18'h209ed, 18'h1fe1f, 18'h0a692,
18'h28e18, 18'h01230, 18'h0e5e2, 18'h3e427, 18'h226f9, 18'h023fb, 18'h0a367, 18'h05d37,
18'h39541, 18'h0d778, 18'h2282c, 18'h0a688, 18'h256b5, 18'h13146, 18'h3f5ba, 18'h1da29,
18'h2bdd2, 18'h228e3, 18'h16f09, 18'h01447, 18'h1b70d, 18'h2a14b, 18'h2d6e3, 18'h3179e,
18'h35f47, 18'h3c648, 18'h1f472, 18'h3ef05, 18'h3286a, 18'h32ff1, 18'h0e056, 18'h0100d,
18'h07530, 18'h09663, 18'h3001d, 18'h367ee, 18'h3ca83, 18'h07ee1, 18'h20827, 18'h3f9bf,
18'h3c577, 18'h1d277, 18'h2f920, 18'h0fac9, 18'h0bd05, 18'h2582e, 18'h20473, 18'h2108a,
18'h1e0cf, 18'h163cc, 18'h05def, 18'h064ef, 18'h2b04e, 18'h1fcc0, 18'h07367, 18'h228d1,
18'h368a0, 18'h1861c, 18'h28523, 18'h0b3bb, 18'h0cde5, 18'h0d8df, 18'h21dbf, 18'h184ab,
18'h1853e, 18'h1c0d9, 18'h114d8, 18'h1afdb, 18'h0fec6, 18'h1b6d0, 18'h0f345, 18'h33cff,
18'h0f7da, 18'h21c40, 18'h033b6, 18'h21afa, 18'h24a32, 18'h1e50d, 18'h27528, 18'h2a116,
18'h35638, 18'h269bf, 18'h10092, 18'h23c84, 18'h0dc90, 18'h292e9, 18'h38e0d, 18'h18887,
18'h0493a, 18'h30c3e, 18'h23cc5, 18'h15593, 18'h35c34, 18'h2d15c, 18'h13812, 18'h38d1c,
18'h18f0e, 18'h07d33, 18'h21081, 18'h39842, 18'h2262d, 18'h2bd66, 18'h20842, 18'h2d3c7,
18'h38998, 18'h09ced, 18'h02049, 18'h3346a, 18'h2d84b, 18'h195ea, 18'h092a0, 18'h229dd,
18'h375b3, 18'h1a02e, 18'h14746, 18'h24366, 18'h332ff, 18'h10837, 18'h12a18, 18'h148c3,
18'h03bae, 18'h3ab4d, 18'h04606, 18'h1dc7f, 18'h135bc, 18'h266c4, 18'h3448b, 18'h37751,
18'h3df71, 18'h3085a, 18'h1ea14, 18'h2e1aa, 18'h3cfea, 18'h21dfd, 18'h25d3d, 18'h22b5f,
18'h060c5, 18'h37bdd, 18'h2863a, 18'h3f829, 18'h34b5f, 18'h3bfcc, 18'h3cec1, 18'h1fad9,
18'h3c733, 18'h34e97, 18'h1fb4c, 18'h33fa7, 18'h0d01f, 18'h18837, 18'h0e1e8, 18'h115f8,
18'h2add2, 18'h24f6a, 18'h25c68, 18'h16568, 18'h1cc9b, 18'h07459, 18'h114d6, 18'h25d3f,
18'h15e49, 18'h3eda2, 18'h2dcb8, 18'h0a25b, 18'h0b08f, 18'h1f646, 18'h2b84c, 18'h141d7,
18'h3ec72, 18'h2c95c, 18'h32c9c, 18'h39aef, 18'h3a57c, 18'h35210, 18'h19cb1, 18'h2bf2c,
18'h1cae4, 18'h3a0db, 18'h02601, 18'h3825a, 18'h3c399, 18'h159ee, 18'h1ede5, 18'h041ea,
18'h0b780, 18'h3ee6d, 18'h3543e, 18'h3e0a3, 18'h11a4f, 18'h0da04, 18'h01fab, 18'h0dd66,
18'h125fd, 18'h08188, 18'h30d57, 18'h26dc2, 18'h101db, 18'h35ee3, 18'h179d6, 18'h3122a,
18'h3436e, 18'h20327, 18'h27f7f, 18'h37a29, 18'h1226e, 18'h2a007, 18'h02e5b, 18'h37322,
18'h06919, 18'h20cf4, 18'h3dd49, 18'h20610, 18'h010f8, 18'h3b8d3, 18'h19968, 18'h0640d,
18'h08ee7, 18'h33fd9, 18'h25cee, 18'h363c1, 18'h215e9, 18'h2ef9c, 18'h04469, 18'h3d2e8,
18'h3ff56, 18'h16bfd, 18'h1f7ce, 18'h2d0ae, 18'h2f1ee, 18'h081ca, 18'h1ec02, 18'h1d107,
18'h09625, 18'h2ee32, 18'h05964, 18'h14b95, 18'h2605d, 18'h3ff77, 18'h02ff9, 18'h07476,
18'h121bc, 18'h39b51, 18'h2259e, 18'h19542, 18'h3053e, 18'h29df8, 18'h2456e, 18'h3a4e7,
18'h0e8e4, 18'h09e1f, 18'h1b5ca, 18'h18f04, 18'h2b5f9, 18'h0d8e5, 18'h1e2a4, 18'h0f291,
18'h13864, 18'h2dc16, 18'h35dd2, 18'h3d200, 18'h061aa, 18'h10c30, 18'h1b975, 18'h27da4,
18'h1db12, 18'h18ec9, 18'h38cf3, 18'h13cfa, 18'h1dde9, 18'h270cb, 18'h1f6b5, 18'h0e6c6,
18'h128ab, 18'h01384, 18'h3df53, 18'h08673, 18'h25ca8, 18'h3e209, 18'h37375, 18'h2c6fe,
18'h0f4cb, 18'h27edb, 18'h0939c, 18'h2fab1, 18'h3ec06, 18'h07fe7, 18'h1d4c6, 18'h0884e,
18'h32d5b, 18'h2bcab, 18'h03eb3, 18'h1fe65, 18'h0fb90, 18'h04e47, 18'h3f8f8, 18'h24b09,
18'h3ad3f, 18'h004e1, 18'h1de0b, 18'h2c583, 18'h38cac, 18'h0219d, 18'h185fc, 18'h1b222,
18'h3bde4, 18'h091bf, 18'h3fda5, 18'h384d3, 18'h22dcd, 18'h3289f, 18'h2e78d, 18'h14c9a,
18'h25f9b, 18'h1ee7b, 18'h2aa11, 18'h26aa6, 18'h11d98, 18'h1c704, 18'h0f986, 18'h0737f,
18'h2734e, 18'h0dfe8, 18'h297f9, 18'h1fdd4, 18'h3db72, 18'h1a7b8, 18'h01e1b, 18'h14dd7,
18'h3a5cb, 18'h3c8fa, 18'h31ee8, 18'h0109f, 18'h0674b, 18'h0a013, 18'h0d96f, 18'h1a401,
18'h1c58c, 18'h14f82, 18'h3c114, 18'h13895, 18'h28e73, 18'h3379f, 18'h3d4c8, 18'h0588d,
18'h14fe0, 18'h1f00d, 18'h10ef0, 18'h13756, 18'h2da91, 18'h2507d, 18'h34446, 18'h07d74,
18'h3e52c, 18'h2d4e9, 18'h3a5e4, 18'h2e904, 18'h3ecab, 18'h20bc2, 18'h0b255, 18'h3e9f5,
18'h2e3f4, 18'h3ba16, 18'h2feaa, 18'h230a2, 18'h25ea0, 18'h1091f, 18'h30f13, 18'h2825f,
18'h2e452, 18'h0e83a, 18'h26f5e, 18'h35b74, 18'h064cb, 18'h2aa85, 18'h2496a, 18'h28086,
18'h1c394, 18'h1a87d, 18'h30f39, 18'h1bec6, 18'h26da3, 18'h345b5, 18'h21f4d, 18'h36eef,
18'h217ee, 18'h032fa, 18'h323b6, 18'h3af97, 18'h00191, 18'h144de, 18'h36f7e, 18'h3982f,
18'h3de33, 18'h01dd8, 18'h3b201, 18'h15c6b, 18'h17803, 18'h32827, 18'h27234, 18'h0cd7f,
18'h0e5df, 18'h1d120, 18'h27e4d, 18'h207c7, 18'h07aa2, 18'h37fa1, 18'h1409e, 18'h3b4b1,
18'h11935, 18'h1ef82, 18'h0d8eb, 18'h08d15, 18'h10621, 18'h23ff3, 18'h21cf7, 18'h3ec13,
18'h1a76c, 18'h148c1, 18'h2786c, 18'h02a78, 18'h24aaf, 18'h2caeb, 18'h3b9ed, 18'h0d72d,
18'h1d058, 18'h16660, 18'h25f62, 18'h02fe5, 18'h06ce1, 18'h3582d, 18'h2dda7, 18'h19931
  };
endpackage

// ===== design/subtract_with_borrow_prng.sv =====
`timescale 1ns / 1ps
// a draw reads the two lag entries, then subtracts and writes the difference back, then
// offers the result; a seed count runs a multiply-accumulate step for each of the 48
// accumulator entries and drains the single multiplier pipeline; the 256th count also copies
// the accumulators into the lag table, runs WARMUP_DRAWS draws and clears the accumulators.
// one item at a time: a new beat is taken only in idle, once the last one is through.
// reset clears control, borrow and indices and sweeps both tables to zero.
module subtract_with_borrow_prng
  import swb_pkg::*;
#(
  parameter int unsigned WARMUP_DRAWS = 1536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_cmd,
  input  logic [VAL_W-1:0] in_seed_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_random_value
);
  localparam int unsigned WU_W = $clog2(WARMUP_DRAWS + 1) < 1 ? 1 : $clog2(WARMUP_DRAWS + 1);

  typedef enum logic [10:0] {
    S_CLR   = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_DRD   = 11'b00000000100,
    S_DWR   = 11'b00000001000,
    S_MAC   = 11'b00000010000,
    S_MDRN  = 11'b00000100000,
    S_COPY  = 11'b00001000000,
    S_WRD   = 11'b00010000000,
    S_WWR   = 11'b00100000000,
    S_ACLR  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  val_t lag_mem [LONG_LAG];
  val_t acc_mem [LONG_LAG];
  idx_t long_r, short_r, cnt_r;
  logic borrow_r;
  logic [POS_W-1:0] pos_r;
  logic [WU_W-1:0] wu_r;
  val_t seed_r, out_r;
  val_t la_r, sa_r;
  // mac pipeline: stage 1 reads rom and acc, stage 2 multiplies, stage 3 writes
  logic v1_r, v2_r;
  idx_t i1_r, i2_r;
  logic [ROM_W-1:0] rom_r;
  val_t acc1_r, acc2_r, prod_r;
  val_t acc_rd_r;
  idx_t acc_ra;
  idx_t long_inc, short_inc;
  logic [ROM_AW-1:0] rom_addr;
  logic [VAL_W:0] diff;
  logic [VAL_W+ROM_W-1:0] mul;

  assign long_inc  = (long_r == LAST_IDX) ? '0 : long_r + 1'b1;
  assign short_inc = (short_r == LAST_IDX) ? '0 : short_r + 1'b1;
  assign diff = {1'b0, la_r} - {1'b0, sa_r} - {{VAL_W{1'b0}}, borrow_r};
  assign mul = seed_r * rom_r;
  // copy reads one entry ahead so acc_rd_r matches the entry being written
  assign acc_ra = (state_r == S_COPY && cnt_r != LAST_IDX) ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    logic [ROM_AW:0] a;
    a = ROM_AW'(ROM_STEP) * cnt_r + {{(ROM_AW+1-POS_W){1'b0}}, pos_r};
    rom_addr = (a >= ROM_LEN) ? ROM_AW'(ROM_LEN - 1) : a[ROM_AW-1:0];
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_random_value = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (cnt_r == LAST_IDX) state_nxt = S_IDLE;
      S_IDLE: if (in_valid) state_nxt = (in_cmd == CMD_DRAW) ? S_DRD : S_MAC;
      S_DRD:  state_nxt = S_DWR;
      S_DWR:  state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      S_MAC:  if (cnt_r == LAST_IDX) state_nxt = S_MDRN;
      S_MDRN: if (!v2_r && !v1_r) state_nxt = (pos_r == '1) ? S_COPY : S_IDLE;
      S_COPY: if (cnt_r == LAST_IDX)
                state_nxt = (WARMUP_DRAWS == 0) ? S_ACLR : S_WRD;
      S_WRD:  state_nxt = S_WWR;
      S_WWR:  if (wu_r == WU_W'(WARMUP_DRAWS - 1)) state_nxt = S_ACLR;
              else state_nxt = S_WRD;
      S_ACLR: if (cnt_r == LAST_IDX) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      cnt_r    <= '0;
      long_r   <= '0;
      short_r  <= '0;
      borrow_r <= 1'b0;
      pos_r    <= '0;
      wu_r     <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r <= (state_r == S_MAC);
      v2_r <= v1_r;
      unique case (state_r)
        S_CLR, S_COPY, S_ACLR, S_MAC:
          cnt_r <= (cnt_r == LAST_IDX) ? '0 : cnt_r + 1'b1;
        default: cnt_r <= cnt_r;
      endcase
      if (state_r == S_IDLE && in_valid) begin
        seed_r <= in_seed_value;
        if (in_cmd == CMD_DRAW) begin
          long_r  <= long_inc;
          short_r <= short_inc;
        end
      end
      if (state_r == S_DWR || state_r == S_WWR) begin
        borrow_r <= diff[VAL_W];
        out_r    <= diff[VAL_W-1:0];
      end
      // warm-up steps the indices after each write but the last so the next read sees them
      if (state_r == S_WWR && wu_r != WU_W'(WARMUP_DRAWS - 1)) begin
        long_r  <= long_inc;
        short_r <= short_inc;
      end
      if (state_r == S_MDRN && !v2_r && !v1_r) pos_r <= pos_r + 1'b1;
      if (state_r == S_COPY && cnt_r == LAST_IDX) begin
        borrow_r <= 1'b0;
        long_r   <= (WARMUP_DRAWS == 0) ? LAST_IDX : '0;
        short_r  <= (WARMUP_DRAWS == 0) ? SHORT_START : SHORT_START + 1'b1;
        wu_r     <= '0;
      end
      if (state_r == S_WWR) wu_r <= wu_r + 1'b1;
    end
  end

  // lag table: one read port pair for the subtract, one write port
  always_ff @(posedge clk) begin
    la_r <= lag_mem[long_r];
    sa_r <= lag_mem[short_r];
    if (state_r == S_CLR) lag_mem[cnt_r] <= '0;
    else if (state_r == S_COPY) lag_mem[cnt_r] <= acc_rd_r;
    else if (state_r == S_DWR || state_r == S_WWR) lag_mem[long_r] <= diff[VAL_W-1:0];
  end

  // accumulators: read at the mac index or copy index, write at the mac tail and in the clear sweeps
  always_ff @(posedge clk) begin
    acc_rd_r <= acc_mem[acc_ra];
    rom_r  <= SEED_ROM[rom_addr];
    i1_r   <= cnt_r;
    i2_r   <= i1_r;
    acc2_r <= acc1_r;
    prod_r <= mul[VAL_W-1:0];
    if (state_r == S_CLR || state_r == S_ACLR) acc_mem[cnt_r] <= '0;
    else if (v2_r) acc_mem[i2_r] <= acc2_r + prod_r;
  end

  // acc_rd_r holds the registered accumulator read
  always_comb acc1_r = acc_rd_r;
endmodule
